>>> design/pks_pkg.sv
package pks_pkg;

  // field widths fixed by the interface
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned ROUND_W     = 24;
  // job count is sized for the largest supported buffer (4096 bytes)
  localparam int unsigned JOB_CNT_W   = 13;

  // hash seeds and salts
  localparam logic [31:0] SEL_SEED    = 32'd13579;
  localparam logic [31:0] SALT_A      = 32'd12345;
  localparam logic [31:0] SALT_B      = 32'd54321;
  localparam logic [31:0] SALT_C      = 32'd98765;
  localparam logic [ROUND_W-1:0] ROUND_RESET = 24'd1000000;

  // selector modulus and reciprocal for the reduction
  localparam logic [16:0] BBS_MOD     = 17'd101273;
  localparam int unsigned RED_SHIFT   = 48;
  localparam logic [31:0] RED_MUL     = 32'((64'd1 << RED_SHIFT) / 64'd101273);
  // reciprocal of 3 for values below 2^17
  localparam int unsigned MOD3_SHIFT  = 18;
  localparam logic [16:0] MOD3_MUL    = 17'(((64'd1 << MOD3_SHIFT) + 64'd2) / 64'd3);

  // input and result items
  typedef struct packed {
    logic [BYTE_W-1:0] pass_byte;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             truncated;
  } out_item_t;

  // one finished password waiting for the back end
  typedef struct packed {
    logic                 bank;
    logic [JOB_CNT_W-1:0] count;
    logic                 truncated;
  } job_t;

  // back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic [1:0] {
    HASH_ADD,
    HASH_XOR,
    HASH_SHIFT
  } hash_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LD_RD,
    BK_LD_MIX,
    BK_SQ,
    BK_RED,
    BK_SUB,
    BK_FIX,
    BK_MOD3,
    BK_WORD,
    BK_DONE
  } back_state_e;

  // sign-extend a byte as a signed char
  function automatic logic [31:0] sx8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] mix_add(input logic [31:0] h, input logic [7:0] b);
    return (h * 32'd33) + sx8(b);
  endfunction

  function automatic logic [31:0] mix_xor(input logic [31:0] h, input logic [7:0] b);
    return (h * 32'd127) ^ sx8(b);
  endfunction

  function automatic logic [31:0] mix_shift(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = (h >> 3) + (h << 15);
    return h ^ (t * sx8(b));
  endfunction

  // one byte step of the selected salted hash
  function automatic logic [31:0] word_mix(input hash_e sel, input logic [31:0] h,
                                           input logic [7:0] b);
    logic [31:0] r;
    unique case (sel)
      HASH_ADD: r = mix_add(h, b);
      HASH_XOR: r = mix_xor(h, b);
      default:  r = mix_shift(h, b);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] salt_of(input hash_e sel);
    logic [31:0] r;
    unique case (sel)
      HASH_ADD: r = SALT_A;
      HASH_XOR: r = SALT_B;
      default:  r = SALT_C;
    endcase
    return r;
  endfunction

endpackage

>>> design/pks_job_fifo.sv
module pks_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pks_pkg::job_t job_i,
  input  logic          pop_i,
  output pks_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);
  import pks_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> design/pks_front.sv
module pks_front #(
  parameter  int unsigned MAX_BYTES = 64,
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1),
  localparam int unsigned IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int unsigned ADDR_W    = IDX_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pks_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output pks_pkg::job_t     job_o,
  input  pks_pkg::release_t rel_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);
  import pks_pkg::*;

  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_data_q;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [1:0]       busy_q, busy_d;
  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] count_inc;
  logic             ovf_inc;

  // the bank being filled must not be held by a pending job
  assign in_stall_o = busy_q[bank_q] | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign has_room   = (count_q < CNT_W'(MAX_BYTES));
  assign count_inc  = has_room ? (count_q + CNT_W'(1)) : count_q;
  assign ovf_inc    = ovf_q | ~has_room;

  // a byte marked last closes the password and queues a job
  assign push_o          = accept & in_item_i.last;
  assign job_o.bank      = bank_q;
  assign job_o.count     = JOB_CNT_W'(count_inc);
  assign job_o.truncated = ovf_inc;

  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (in_item_i.last) begin
        busy_d[bank_q] = 1'b1;
        bank_d         = ~bank_q;
        count_d        = '0;
        ovf_d          = 1'b0;
      end else begin
        count_d = count_inc;
        ovf_d   = ovf_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

  // double-banked password store
  always_ff @(posedge clk_i) begin
    if (accept && has_room) begin
      mem[{bank_q, count_q[IDX_W-1:0]}] <= in_item_i.pass_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/pks_back.sv
module pks_back #(
  parameter  int unsigned MAX_BYTES = 64,
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1),
  localparam int unsigned IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int unsigned ADDR_W    = IDX_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pks_pkg::ROUND_W-1:0]   round_count_i,
  input  logic                          q_empty_i,
  input  pks_pkg::job_t                 job_i,
  output logic                          pop_o,
  output pks_pkg::release_t             rel_o,
  output logic                          rd_en_o,
  output logic [ADDR_W-1:0]             rd_addr_o,
  input  logic [7:0]                    rd_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pks_pkg::out_item_t            out_item_o
);
  import pks_pkg::*;

  back_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               bank_q, bank_d;
  logic               trunc_q, trunc_d;
  logic [31:0]        sel_q, sel_d;
  logic [31:0]        key_q, key_d;
  logic [31:0]        sq_q, sq_d;
  logic [15:0]        qe_q, qe_d;
  logic [17:0]        rem_q, rem_d;
  hash_e              hsel_q, hsel_d;
  logic [31:0]        h_q, h_d;
  logic [1:0]         byte_q, byte_d;
  logic [ROUND_W-1:0] rnd_q, rnd_d;

  logic [CNT_W-1:0]   cnt_dec;
  logic [63:0]        red_prod;
  logic [31:0]        qd_prod;
  logic [33:0]        m3_prod;
  logic [15:0]        q3;
  logic [16:0]        m3_rem;
  logic [31:0]        h_next;
  logic [7:0]         key_byte;

  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign red_prod = 64'(sq_q) * 64'(RED_MUL);
  assign qd_prod  = 32'(qe_q) * 32'(BBS_MOD);
  assign m3_prod  = 34'(sel_q[16:0]) * 34'(MOD3_MUL);
  assign q3       = m3_prod[33:18];
  assign m3_rem   = sel_q[16:0] - 17'(18'(q3) * 18'd3);
  assign key_byte = key_q[{byte_q, 3'b000} +: 8];
  assign h_next   = word_mix(hsel_q, h_q, key_byte);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = BK_LD_RD;
      end
      BK_LD_RD:  state_d = BK_LD_MIX;
      BK_LD_MIX: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = (round_count_i == '0) ? BK_DONE : BK_SQ;
        end else begin
          state_d = BK_LD_RD;
        end
      end
      BK_SQ:   state_d = BK_RED;
      BK_RED:  state_d = BK_SUB;
      BK_SUB:  state_d = BK_FIX;
      BK_FIX:  state_d = BK_MOD3;
      BK_MOD3: state_d = BK_WORD;
      BK_WORD: begin
        if (byte_q == 2'd0) begin
          state_d = (rnd_q == ROUND_W'(1)) ? BK_DONE : BK_SQ;
        end
      end
      BK_DONE: begin
        if (!out_stall_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d     = cnt_q;
    bank_d    = bank_q;
    trunc_d   = trunc_q;
    sel_d     = sel_q;
    key_d     = key_q;
    sq_d      = sq_q;
    qe_d      = qe_q;
    rem_d     = rem_q;
    hsel_d    = hsel_q;
    h_d       = h_q;
    byte_d    = byte_q;
    rnd_d     = rnd_q;
    pop_o     = 1'b0;
    rel_o     = '0;
    rd_en_o   = 1'b0;
    rd_addr_o = {bank_q, cnt_dec[IDX_W-1:0]};
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cnt_d   = job_i.count[CNT_W-1:0];
          bank_d  = job_i.bank;
          trunc_d = job_i.truncated;
          sel_d   = SEL_SEED;
          key_d   = SALT_B;
        end
      end
      // fetch stored bytes from the last one down
      BK_LD_RD: begin
        rd_en_o = 1'b1;
      end
      BK_LD_MIX: begin
        sel_d = mix_add(sel_q, rd_data_i);
        key_d = mix_xor(key_q, rd_data_i);
        cnt_d = cnt_dec;
        rnd_d = round_count_i;
        if (cnt_q == CNT_W'(1)) begin
          rel_o.valid = 1'b1;
          rel_o.bank  = bank_q;
        end
      end
      // selector update: square, then reduce by reciprocal multiply
      BK_SQ: begin
        sq_d = sel_q * sel_q;
      end
      BK_RED: begin
        qe_d = red_prod[63:48];
      end
      BK_SUB: begin
        rem_d = 18'(sq_q - qd_prod);
      end
      BK_FIX: begin
        if (rem_q >= 18'(BBS_MOD)) begin
          sel_d = 32'(rem_q - 18'(BBS_MOD));
        end else begin
          sel_d = 32'(rem_q);
        end
      end
      // pick the salted hash from selector mod 3
      BK_MOD3: begin
        unique case (m3_rem[1:0])
          2'd0:    hsel_d = HASH_ADD;
          2'd1:    hsel_d = HASH_XOR;
          default: hsel_d = HASH_SHIFT;
        endcase
        h_d    = salt_of(hsel_d);
        byte_d = 2'd3;
      end
      // one key byte per cycle, most significant first
      BK_WORD: begin
        h_d    = h_next;
        byte_d = byte_q - 2'd1;
        if (byte_q == 2'd0) begin
          key_d = h_next;
          rnd_d = rnd_q - ROUND_W'(1);
        end
      end
      BK_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o          = (state_q == BK_DONE);
  assign out_item_o.key       = key_q;
  assign out_item_o.truncated = trunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    bank_q  <= bank_d;
    trunc_q <= trunc_d;
    sel_q   <= sel_d;
    key_q   <= key_d;
    sq_q    <= sq_d;
    qe_q    <= qe_d;
    rem_q   <= rem_d;
    hsel_q  <= hsel_d;
    h_q     <= h_d;
    byte_q  <= byte_d;
    rnd_q   <= rnd_d;
  end

endmodule

>>> design/password_key_stretcher_top.sv
// password key stretcher
//
// input channel (in_valid_i / in_stall_o / in_item_i) takes one password
// byte per cycle while not stalled; the item with last set closes the
// password. bytes past MAX_PASSWORD_BYTES are dropped and reported
// through the truncated flag. result channel (out_valid_o / out_stall_i /
// out_item_o) gives one key per password. the round count is written
// through cfg_valid_i / cfg_data_i, always ready.
//
// the round count must be written only while the block is idle; the block
// itself does not enforce this. bytes go into one of two store banks; a
// closed password is queued as a job in a two-entry queue, so the next
// password loads while the previous one is hashed. input stalls only while
// the bank it would fill is held. the stored bytes are read and mixed one
// at a time; each round squares and reduces the selector, then hashes the
// key one byte at a time through a single mix unit. a result holds on the
// outputs while out_stall_i is high and the back end waits; loading
// continues. reset empties the queue and both banks, clears byte count and
// overflow, and sets the round count to 1000000.
module password_key_stretcher_top #(
  parameter int unsigned MAX_PASSWORD_BYTES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pks_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pks_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pks_pkg::ROUND_W-1:0] cfg_data_i
);
  import pks_pkg::*;

  localparam int unsigned IDX_W  = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
  localparam int unsigned ADDR_W = IDX_W + 1;

  logic [ROUND_W-1:0] round_count_q;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  job_t               job_in;
  job_t               job_out;
  release_t           rel;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;

  // round count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= ROUND_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      round_count_q <= cfg_data_i;
    end
  end

  pks_front #(
    .MAX_BYTES (MAX_PASSWORD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (job_in),
    .rel_i      (rel),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  pks_job_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pks_back #(
    .MAX_BYTES (MAX_PASSWORD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .round_count_i (round_count_q),
    .q_empty_i     (q_empty),
    .job_i         (job_out),
    .pop_o         (q_pop),
    .rel_o         (rel),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  // job queue never overflows or underflows
  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("job queue push while full");

  a_queue_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("job queue pop while empty");

  // back end takes a new job only after its result was delivered
  a_pop_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !out_valid_o) else $error("job popped while result pending");

  // a bank is handed back only during the store read, never with a result up
  a_release_in_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel.valid |-> !out_valid_o && !q_pop) else $error("bank released out of load phase");

endmodule
